// File: rtl/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types, codes and constants of the first-fit pool allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int unsigned POOLS_DEF               = 4;
  localparam int unsigned FIRST_POOL_GRANULES_DEF = 256;
  localparam int unsigned GRANULE_BYTES           = 16;
  localparam int unsigned GRAN_SHIFT              = 4;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned REQ_W  = 16;
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned COPY_W = 15;
  localparam int unsigned CFG_W  = 3;
  localparam int unsigned G_W    = REQ_W + 1 - GRAN_SHIFT;

  localparam logic [CFG_W-1:0] LIMIT_RESET = 3'd4;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESIZE = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOM   = 2'd1;
  localparam logic [STAT_W-1:0] ST_MOVED = 2'd2;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_AL_INIT,
    CMD_I_INC,
    CMD_OPEN,
    CMD_WK_START,
    CMD_HDR,
    CMD_HDR_FREE,
    CMD_MERGE,
    CMD_FIT,
    CMD_NEXT,
    CMD_SPLIT_A,
    CMD_SPLIT_B,
    CMD_SET_RES_N,
    CMD_FF_HDR,
    CMD_RD_N,
    CMD_FREE_WR,
    CMD_SAVE_OLD,
    CMD_RES_ADDR,
    CMD_ALLOC_RES,
    CMD_SET_OOM,
    CMD_MOVE,
    CMD_PUBLISH
  } cmd_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              addr_zero;
    logic              pool_found;
    logic              i_end;
    logic              i_open;
    logic              i_ffv;
    logic              i_lim;
    logic              hn_alloc;
    logic              hn_last;
    logic              fit;
    logic              old_gt_g;
    logic              rd_alloc;
    logic              rd_last;
    logic              p_ffv;
    logic              res_zero;
  } dp_status_t;

endpackage

// File: rtl/first_fit_pool_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_pool_allocator
// First-fit heap allocator over pools of doubling size, with forward merging.
// ----------------------------------------------------------------------------
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+------------------------------------------
//  request  | in_valid_i / in_ready_o | func_i, req_size_i, address_i
//  result   | out_valid_o/out_ready_i | result_address_o, status_o, copy_bytes_o
//  config   | cfg_we_i                | cfg_wdata_i (pool limit)
//
//  One item is worked on at a time. Every step of the walk reads one node
//  header from the header RAM, which has one write and one read port, so the
//  time per item is set by the number of headers visited, the pools skipped
//  and the search for a new first free node.
//  Reset clears the pool-open and first-free valid bits; the header RAM needs
//  no clearing, since a pool's first header is written when the pool opens.
//  A finished result sits in an output register, so the next item may be
//  accepted while it waits; a second result waits until the first is taken.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator #(
  parameter int unsigned POOLS               = ffpa_pkg::POOLS_DEF,
  parameter int unsigned FIRST_POOL_GRANULES = ffpa_pkg::FIRST_POOL_GRANULES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ffpa_pkg::FUNC_W-1:0] func_i,
  input  logic [ffpa_pkg::REQ_W-1:0]  req_size_i,
  input  logic [ffpa_pkg::ADDR_W-1:0] address_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ffpa_pkg::ADDR_W-1:0] result_address_o,
  output logic [ffpa_pkg::STAT_W-1:0] status_o,
  output logic [ffpa_pkg::COPY_W-1:0] copy_bytes_o,
  input  logic                        cfg_we_i,
  input  logic [ffpa_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import ffpa_pkg::*;

  // Commands flow from the sequencer, condition flags flow back.
  cmd_e       cmd;
  dp_status_t dp_status;

  ffpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .st_i        (dp_status),
    .cmd_o       (cmd)
  );

  ffpa_datapath #(
    .POOLS               (POOLS),
    .FIRST_POOL_GRANULES (FIRST_POOL_GRANULES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (dp_status),
    .func_i           (func_i),
    .req_size_i       (req_size_i),
    .address_i        (address_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .result_address_o (result_address_o),
    .status_code_o    (status_o),
    .copy_bytes_o     (copy_bytes_o)
  );

endmodule

// File: rtl/ffpa_datapath.sv
// ----------------------------------------------------------------------------
// ffpa_datapath
// Header memory, pool bookkeeping and the arithmetic of the allocator walk.
// ----------------------------------------------------------------------------
module ffpa_datapath #(
  parameter int unsigned POOLS               = ffpa_pkg::POOLS_DEF,
  parameter int unsigned FIRST_POOL_GRANULES = ffpa_pkg::FIRST_POOL_GRANULES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ffpa_pkg::cmd_e                 cmd_i,
  output ffpa_pkg::dp_status_t           status_o,
  input  logic [ffpa_pkg::FUNC_W-1:0]    func_i,
  input  logic [ffpa_pkg::REQ_W-1:0]     req_size_i,
  input  logic [ffpa_pkg::ADDR_W-1:0]    address_i,
  input  logic                           cfg_we_i,
  input  logic [ffpa_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic [ffpa_pkg::ADDR_W-1:0]    result_address_o,
  output logic [ffpa_pkg::STAT_W-1:0]    status_code_o,
  output logic [ffpa_pkg::COPY_W-1:0]    copy_bytes_o
);
  import ffpa_pkg::*;

  localparam int unsigned TOTAL = FIRST_POOL_GRANULES * ((1 << POOLS) - 1);
  localparam int unsigned MAXG  = FIRST_POOL_GRANULES << (POOLS - 1);
  localparam int unsigned NW    = $clog2(TOTAL);
  localparam int unsigned EW    = $clog2(TOTAL + 1);
  localparam int unsigned SW    = $clog2(MAXG + 1);
  localparam int unsigned HW    = SW + 2;
  localparam int unsigned MW0   = (EW > G_W) ? EW : G_W;
  localparam int unsigned MW1   = (MW0 > ADDR_W) ? MW0 : ADDR_W;
  localparam int unsigned CW    = MW1 + 2;
  localparam int unsigned PW    = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int unsigned IW    = $clog2(POOLS + 1);
  localparam int unsigned LW    = ((IW > CFG_W) ? IW : CFG_W) + 1;
  localparam int unsigned A_B   = HW - 1;
  localparam int unsigned L_B   = HW - 2;

  function automatic logic [CW-1:0] hdr_end(input logic [HW-1:0] h,
                                            input logic [CW-1:0] n,
                                            input logic [CW-1:0] e);
    logic [CW-1:0] s;
    s = CW'(h[SW-1:0]);
    if (s == '0 || s > e - n) begin
      return e;
    end
    return n + s;
  endfunction

  logic [CW-1:0] base_c [POOLS];
  logic [CW-1:0] end_c  [POOLS];
  logic [CW-1:0] gran_c [POOLS];

  for (genvar k = 0; k < POOLS; k++) begin : g_pool
    assign base_c[k] = CW'(FIRST_POOL_GRANULES * ((1 << k) - 1));
    assign gran_c[k] = CW'(FIRST_POOL_GRANULES << k);
    assign end_c[k]  = CW'(FIRST_POOL_GRANULES * ((1 << (k + 1)) - 1));
  end

  logic [HW-1:0] mem [TOTAL];
  logic [HW-1:0] rdata_q;
  logic          we;
  logic [CW-1:0] waddr, raddr;
  logic [HW-1:0] wdata;

  logic [FUNC_W-1:0] func_q, func_d;
  logic [G_W-1:0]    g_q, g_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [EW-1:0]     n_q, n_d;
  logic [PW-1:0]     p_q, p_d;
  logic [IW-1:0]     i_q, i_d;
  logic [HW-1:0]     hn_q, hn_d;
  logic [SW-1:0]     old_q, old_d;
  logic [ADDR_W-1:0] res_q, res_d, ores_q, ores_d;
  logic [STAT_W-1:0] stat_q, stat_d, ostat_q, ostat_d;
  logic [COPY_W-1:0] copy_q, copy_d, ocopy_q, ocopy_d;
  logic [EW-1:0]     ff_q [POOLS];
  logic [EW-1:0]     ff_d [POOLS];
  logic [POOLS-1:0]  ffv_q, ffv_d, open_q, open_d;
  logic [CFG_W-1:0]  limit_q;

  logic [PW-1:0]     ip, fp;
  logic              found;
  logic [IW-1:0]     first;
  logic [CW-1:0]     n_c, g_c, end_p, hn_end, rd_end, m_end, avail, nx, naddr;
  logic              hn_last, rd_last, m_last, fit, split;
  logic [REQ_W:0]    req_up;

  assign ip      = i_q[PW-1:0];
  assign n_c     = CW'(n_q);
  assign g_c     = CW'(g_q);
  assign end_p   = end_c[p_q];
  assign hn_end  = hdr_end(hn_q, n_c, end_p);
  assign hn_last = hn_q[L_B] || hn_end == end_p;
  assign rd_end  = hdr_end(rdata_q, n_c, end_p);
  assign rd_last = rdata_q[L_B] || rd_end == end_p;
  assign m_end   = hdr_end(rdata_q, hn_end, end_p);
  assign m_last  = rdata_q[L_B] || m_end == end_p;
  assign avail   = hn_end - n_c - CW'(1);
  assign fit     = avail >= g_c;
  assign split   = avail > g_c + CW'(1);
  assign nx      = n_c + g_c + CW'(1);
  assign naddr   = CW'(addr_q) - CW'(1);
  assign req_up  = {1'b0, req_size_i} + (REQ_W + 1)'(GRANULE_BYTES - 1);

  // Pool that holds a header granule, and the smallest pool a request fits.
  always_comb begin
    found = 1'b0;
    fp    = '0;
    first = '0;
    for (int k = 0; k < POOLS; k++) begin
      if (open_q[k] && naddr >= base_c[k] && naddr < end_c[k]) begin
        found = 1'b1;
        fp    = PW'(k);
      end
      if (gran_c[k] - CW'(1) < g_c) begin
        first = first + IW'(1);
      end
    end
  end

  always_comb begin
    status_o.func       = func_q;
    status_o.addr_zero  = addr_q == '0;
    status_o.pool_found = found;
    status_o.i_end      = i_q >= IW'(POOLS);
    status_o.i_open     = open_q[ip];
    status_o.i_ffv      = ffv_q[ip];
    status_o.i_lim      = LW'(i_q) >= LW'(limit_q);
    status_o.hn_alloc   = hn_q[A_B];
    status_o.hn_last    = hn_last;
    status_o.fit        = fit;
    status_o.old_gt_g   = avail > g_c;
    status_o.rd_alloc   = rdata_q[A_B];
    status_o.rd_last    = rd_last;
    status_o.p_ffv      = ffv_q[p_q];
    status_o.res_zero   = res_q == '0;
  end

  always_comb begin
    func_d  = func_q;
    g_d     = g_q;
    addr_d  = addr_q;
    n_d     = n_q;
    p_d     = p_q;
    i_d     = i_q;
    hn_d    = hn_q;
    old_d   = old_q;
    res_d   = res_q;
    stat_d  = stat_q;
    copy_d  = copy_q;
    ores_d  = ores_q;
    ostat_d = ostat_q;
    ocopy_d = ocopy_q;
    ff_d    = ff_q;
    ffv_d   = ffv_q;
    open_d  = open_q;
    we      = 1'b0;
    waddr   = n_c;
    wdata   = hn_q;
    raddr   = n_c;
    unique case (cmd_i)
      CMD_NOP: begin
      end
      CMD_LOAD: begin
        func_d = func_i;
        g_d    = req_up[REQ_W:GRAN_SHIFT];
        addr_d = address_i;
        res_d  = '0;
        stat_d = ST_DONE;
        copy_d = '0;
      end
      CMD_AL_INIT: i_d = first;
      CMD_I_INC:   i_d = i_q + IW'(1);
      CMD_OPEN: begin
        open_d[ip] = 1'b1;
        we         = 1'b1;
        waddr      = base_c[ip];
        wdata      = {1'b0, 1'b1, SW'(gran_c[ip])};
        ff_d[ip]   = EW'(base_c[ip]);
        ffv_d[ip]  = 1'b1;
      end
      CMD_WK_START: begin
        p_d   = ip;
        n_d   = ff_q[ip];
        raddr = CW'(ff_q[ip]);
      end
      CMD_HDR: begin
        hn_d  = rdata_q;
        raddr = rd_end;
      end
      CMD_HDR_FREE: begin
        hn_d      = rdata_q;
        hn_d[A_B] = 1'b0;
        raddr     = rd_end;
      end
      CMD_MERGE: begin
        // The merged header of a free node is stored at once, whether or not the node is then taken.
        if (!hn_q[A_B] && !hn_last && !rdata_q[A_B]) begin
          hn_d  = {hn_q[A_B], m_last, SW'(m_end - n_c)};
          we    = 1'b1;
          wdata = {hn_q[A_B], m_last, SW'(m_end - n_c)};
        end
      end
      CMD_FIT: begin
        hn_d[A_B] = 1'b1;
        if (ff_q[p_q] == n_q) begin
          ffv_d[p_q] = 1'b0;
        end
      end
      CMD_NEXT: begin
        n_d   = EW'(hn_end);
        raddr = hn_end;
      end
      CMD_SPLIT_A: begin
        if (split) begin
          we    = 1'b1;
          waddr = nx;
          wdata = {1'b0, hn_last, SW'(hn_end - nx)};
          if (!ffv_d[p_q] || nx < CW'(ff_q[p_q])) begin
            ff_d[p_q]  = EW'(nx);
            ffv_d[p_q] = 1'b1;
          end
        end
      end
      CMD_SPLIT_B: begin
        we    = 1'b1;
        wdata = split ? {hn_q[A_B], 1'b0, SW'(g_c + CW'(1))} : hn_q;
      end
      CMD_SET_RES_N: res_d = ADDR_W'(n_c + CW'(1));
      CMD_FF_HDR: begin
        if (!rdata_q[A_B]) begin
          ff_d[p_q]  = n_q;
          ffv_d[p_q] = 1'b1;
        end
        n_d   = EW'(rd_end);
        raddr = rd_end;
      end
      CMD_RD_N: begin
        n_d   = EW'(naddr);
        p_d   = fp;
        raddr = naddr;
      end
      CMD_FREE_WR: begin
        we = 1'b1;
        if (!ffv_q[p_q] || n_q < ff_q[p_q]) begin
          ff_d[p_q]  = n_q;
          ffv_d[p_q] = 1'b1;
        end
      end
      CMD_SAVE_OLD:  old_d  = SW'(avail);
      CMD_RES_ADDR:  res_d  = addr_q;
      CMD_ALLOC_RES: stat_d = (res_q == '0) ? ST_OOM : ST_DONE;
      CMD_SET_OOM: begin
        res_d  = '0;
        stat_d = ST_OOM;
      end
      CMD_MOVE: begin
        copy_d = COPY_W'({old_q, GRAN_SHIFT'(0)});
        stat_d = ST_MOVED;
      end
      CMD_PUBLISH: begin
        ores_d  = res_q;
        ostat_d = stat_q;
        ocopy_d = copy_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr[NW-1:0]] <= wdata;
    end
    rdata_q <= mem[raddr[NW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= '0;
      ffv_q   <= '0;
      limit_q <= LIMIT_RESET;
    end else begin
      open_q <= open_d;
      ffv_q  <= ffv_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    g_q     <= g_d;
    addr_q  <= addr_d;
    n_q     <= n_d;
    p_q     <= p_d;
    i_q     <= i_d;
    hn_q    <= hn_d;
    old_q   <= old_d;
    res_q   <= res_d;
    stat_q  <= stat_d;
    copy_q  <= copy_d;
    ores_q  <= ores_d;
    ostat_q <= ostat_d;
    ocopy_q <= ocopy_d;
    ff_q    <= ff_d;
  end

  assign result_address_o = ores_q;
  assign status_code_o    = ostat_q;
  assign copy_bytes_o     = ocopy_q;

endmodule

// File: rtl/ffpa_ctrl.sv
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Sequencer of the allocator: issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module ffpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  ffpa_pkg::dp_status_t st_i,
  output ffpa_pkg::cmd_e       cmd_o
);
  import ffpa_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_AL_SCAN = 5'd2;
  localparam logic [4:0] S_AL_OPEN = 5'd3;
  localparam logic [4:0] S_AL_OPN2 = 5'd4;
  localparam logic [4:0] S_WK_HDR  = 5'd5;
  localparam logic [4:0] S_WK_MG   = 5'd6;
  localparam logic [4:0] S_WK_CHK  = 5'd7;
  localparam logic [4:0] S_SPL_A   = 5'd8;
  localparam logic [4:0] S_SPL_B   = 5'd9;
  localparam logic [4:0] S_AL_FF   = 5'd10;
  localparam logic [4:0] S_FF_HDR  = 5'd11;
  localparam logic [4:0] S_AL_END  = 5'd12;
  localparam logic [4:0] S_MOVE    = 5'd13;
  localparam logic [4:0] S_MV_RD   = 5'd14;
  localparam logic [4:0] S_FR_HDR  = 5'd15;
  localparam logic [4:0] S_FR_MG   = 5'd16;
  localparam logic [4:0] S_FR_WR   = 5'd17;
  localparam logic [4:0] S_RS_HDR  = 5'd18;
  localparam logic [4:0] S_RS_CHK  = 5'd19;
  localparam logic [4:0] S_RS_AL   = 5'd20;
  localparam logic [4:0] S_RS_DONE = 5'd21;
  localparam logic [4:0] S_PUB     = 5'd22;

  logic [4:0] state_q, state_d;
  logic       in_alloc_q, in_alloc_d;
  logic       is_resize_q, is_resize_d;
  logic       opened_q, opened_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    in_alloc_d  = in_alloc_q;
    is_resize_d = is_resize_q;
    opened_d    = opened_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = CMD_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        priority if (st_i.func == FUNC_ALLOC ||
                     (st_i.func == FUNC_RESIZE && st_i.addr_zero)) begin
          cmd_o       = CMD_AL_INIT;
          in_alloc_d  = 1'b1;
          is_resize_d = 1'b0;
          opened_d    = 1'b0;
          state_d     = S_AL_SCAN;
        end else if (st_i.func == FUNC_FREE) begin
          if (st_i.addr_zero || !st_i.pool_found) begin
            state_d = S_PUB;
          end else begin
            cmd_o   = CMD_RD_N;
            state_d = S_FR_HDR;
          end
        end else if (st_i.func == FUNC_RESIZE) begin
          if (!st_i.pool_found) begin
            cmd_o   = CMD_SET_OOM;
            state_d = S_PUB;
          end else begin
            cmd_o   = CMD_RD_N;
            state_d = S_RS_HDR;
          end
        end else begin
          state_d = S_PUB;
        end
      end
      S_AL_SCAN: begin
        priority if (st_i.i_end) begin
          cmd_o   = CMD_AL_INIT;
          state_d = S_AL_OPEN;
        end else if (st_i.i_open && st_i.i_ffv) begin
          cmd_o   = CMD_WK_START;
          state_d = S_WK_HDR;
        end else begin
          cmd_o = CMD_I_INC;
        end
      end
      S_AL_OPEN: begin
        priority if (st_i.i_end || (!st_i.i_open && st_i.i_lim)) begin
          state_d = S_AL_END;
        end else if (st_i.i_open) begin
          cmd_o = CMD_I_INC;
        end else begin
          cmd_o    = CMD_OPEN;
          opened_d = 1'b1;
          state_d  = S_AL_OPN2;
        end
      end
      S_AL_OPN2: begin
        cmd_o   = CMD_WK_START;
        state_d = S_WK_HDR;
      end
      S_WK_HDR: begin
        cmd_o   = CMD_HDR;
        state_d = S_WK_MG;
      end
      S_WK_MG: begin
        cmd_o   = CMD_MERGE;
        state_d = S_WK_CHK;
      end
      S_WK_CHK: begin
        priority if (!st_i.hn_alloc && st_i.fit) begin
          cmd_o   = CMD_FIT;
          state_d = S_SPL_A;
        end else if (st_i.hn_last) begin
          if (opened_q) begin
            state_d = S_AL_END;
          end else begin
            cmd_o   = CMD_I_INC;
            state_d = S_AL_SCAN;
          end
        end else begin
          cmd_o   = CMD_NEXT;
          state_d = S_WK_HDR;
        end
      end
      S_SPL_A: begin
        cmd_o   = CMD_SPLIT_A;
        state_d = S_SPL_B;
      end
      S_SPL_B: begin
        cmd_o   = CMD_SPLIT_B;
        state_d = in_alloc_q ? S_AL_FF : S_RS_DONE;
      end
      S_AL_FF: begin
        cmd_o   = CMD_SET_RES_N;
        state_d = st_i.p_ffv ? S_AL_END : S_FF_HDR;
      end
      S_FF_HDR: begin
        cmd_o = CMD_FF_HDR;
        if (!st_i.rd_alloc || st_i.rd_last) begin
          state_d = S_AL_END;
        end
      end
      S_AL_END: begin
        priority if (!is_resize_q) begin
          cmd_o   = CMD_ALLOC_RES;
          state_d = S_PUB;
        end else if (st_i.res_zero) begin
          cmd_o   = CMD_SET_OOM;
          state_d = S_PUB;
        end else begin
          cmd_o   = CMD_MOVE;
          state_d = S_MV_RD;
        end
      end
      S_MV_RD: begin
        cmd_o   = CMD_RD_N;
        state_d = S_FR_HDR;
      end
      S_MOVE: begin
        cmd_o   = CMD_MOVE;
        state_d = S_MV_RD;
      end
      S_FR_HDR: begin
        cmd_o   = CMD_HDR_FREE;
        state_d = S_FR_MG;
      end
      S_FR_MG: begin
        cmd_o   = CMD_MERGE;
        state_d = S_FR_WR;
      end
      S_FR_WR: begin
        cmd_o   = CMD_FREE_WR;
        state_d = S_PUB;
      end
      S_RS_HDR: begin
        cmd_o   = CMD_HDR;
        state_d = S_RS_CHK;
      end
      S_RS_CHK: begin
        cmd_o = CMD_SAVE_OLD;
        priority if (!st_i.fit) begin
          state_d = S_RS_AL;
        end else if (st_i.old_gt_g) begin
          in_alloc_d = 1'b0;
          state_d    = S_SPL_A;
        end else begin
          state_d = S_RS_DONE;
        end
      end
      S_RS_AL: begin
        cmd_o       = CMD_AL_INIT;
        in_alloc_d  = 1'b1;
        is_resize_d = 1'b1;
        opened_d    = 1'b0;
        state_d     = S_AL_SCAN;
      end
      S_RS_DONE: begin
        cmd_o   = CMD_RES_ADDR;
        state_d = S_PUB;
      end
      S_PUB: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o       = CMD_PUBLISH;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_alloc_q  <= 1'b0;
      is_resize_q <= 1'b0;
      opened_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_alloc_q  <= in_alloc_d;
      is_resize_q <= is_resize_d;
      opened_q    <= opened_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/ffpa_checker.sv
// ----------------------------------------------------------------------------
// ffpa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffpa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [ffpa_pkg::FUNC_W-1:0] func_i,
  input logic [ffpa_pkg::REQ_W-1:0]  req_size_i,
  input logic [ffpa_pkg::ADDR_W-1:0] address_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [ffpa_pkg::ADDR_W-1:0] result_address_o,
  input logic [ffpa_pkg::STAT_W-1:0] status_o,
  input logic [ffpa_pkg::COPY_W-1:0] copy_bytes_o,
  input logic                        cfg_we_i,
  input logic [ffpa_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import ffpa_pkg::*;

  // A result that is not taken stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_address_o)
                                   && $stable(status_o) && $stable(copy_bytes_o))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_DONE || status_o == ST_OOM || status_o == ST_MOVED)
    else $error("undefined status code");

  a_oom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OOM |-> result_address_o == '0)
    else $error("failed request returned an address");

  a_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_MOVED |-> copy_bytes_o == '0)
    else $error("copy size without a move");

  a_moved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_MOVED |-> result_address_o != '0)
    else $error("move without a new block");

endmodule

bind first_fit_pool_allocator ffpa_checker u_ffpa_checker (.*);
